// ----- src/mws_pkg.sv -----
// ----------------------------------------------------------------------------
// mws_pkg
// Shared widths, register codes and lane types of the mecanum wheel speed
// pipeline.
// ----------------------------------------------------------------------------
package mws_pkg;

   localparam int SPEED_BITS = 16;
   localparam int RPM_BITS   = 16;
   localparam int NUM_WHEELS = 4;

   localparam int LEVER_W    = 12;
   localparam int GAIN_W     = 20;
   localparam int LIMIT_W    = 15;
   localparam int CSR_DATA_W = GAIN_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [LEVER_W-1:0] LEVER_RESET = LEVER_W'(200);
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(48894);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = '0;

   // surface speed in um/s and its magnitude
   localparam int SURF_W = 30;
   localparam int MAG_W  = 28;
   // wheel rpm before limiting
   localparam int RAW_W  = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROTATION_LEVER = 2'd0,
      REG_RPM_GAIN       = 2'd1,
      REG_RPM_LIMIT      = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } surf_type;

   typedef struct packed {
      logic             neg;
      logic [RAW_W-1:0] mag;
   } raw_type;

   typedef struct packed {
      logic               neg;
      logic [RAW_W-1:0]   raw;
      logic [LIMIT_W-1:0] quo;
   } wheel_type;

endpackage

// ----- src/mws_kin.sv -----
// ----------------------------------------------------------------------------
// mws_kin
// Two stages: scaled chassis terms, then the four wheel surface speeds as
// sign and magnitude.
// ----------------------------------------------------------------------------
module mws_kin
   import mws_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic signed [SPEED_BITS-1:0] forward_speed,
   input  logic signed [SPEED_BITS-1:0] side_speed,
   input  logic signed [SPEED_BITS-1:0] yaw_rate,
   input  logic [LEVER_W-1:0]           lever,
   output logic                         out_valid,
   input  logic                         out_stall,
   output surf_type [NUM_WHEELS-1:0]    surf
);

   localparam int EXT_W = SURF_W - SPEED_BITS;
   localparam int MM_PER_M = 1000;
   // wheel order: front left, front right, rear left, rear right
   localparam logic [NUM_WHEELS-1:0] SIDE_NEG = 4'b1001;
   localparam logic [NUM_WHEELS-1:0] TURN_NEG = 4'b0101;

   logic [1:0] valid_ff;
   logic [1:0] go;

   logic signed [SURF_W-1:0] fwd_ff, fwd_in;
   logic signed [SURF_W-1:0] side_ff, side_in;
   logic signed [SURF_W-1:0] turn_ff, turn_in;
   logic signed [SURF_W-1:0] sum [NUM_WHEELS];
   logic signed [SURF_W-1:0] abs_sum [NUM_WHEELS];
   surf_type [NUM_WHEELS-1:0] surf_ff, surf_in;

   always_comb begin
      go[1] = !valid_ff[1] || !out_stall;
      go[0] = !valid_ff[0] || go[1];
   end

   assign in_stall  = !go[0];
   assign out_valid = valid_ff[1];
   assign surf      = surf_ff;

   always_comb begin
      fwd_in  = $signed({{EXT_W{forward_speed[SPEED_BITS-1]}}, forward_speed})
              * $signed(SURF_W'(MM_PER_M));
      side_in = $signed({{EXT_W{side_speed[SPEED_BITS-1]}}, side_speed})
              * $signed(SURF_W'(MM_PER_M));
      turn_in = $signed({{EXT_W{yaw_rate[SPEED_BITS-1]}}, yaw_rate})
              * $signed({{(SURF_W-LEVER_W){1'b0}}, lever});
   end

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         sum[w] = fwd_ff + (SIDE_NEG[w] ? -side_ff : side_ff)
                + (TURN_NEG[w] ? -turn_ff : turn_ff);
         abs_sum[w] = sum[w][SURF_W-1] ? -sum[w] : sum[w];
         surf_in[w].neg = sum[w][SURF_W-1];
         surf_in[w].mag = abs_sum[w][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (go[0]) begin
            valid_ff[0] <= in_valid;
         end
         if (go[1]) begin
            valid_ff[1] <= valid_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         fwd_ff  <= fwd_in;
         side_ff <= side_in;
         turn_ff <= turn_in;
      end
      if (go[1]) begin
         surf_ff <= surf_in;
      end
   end

   // a negative surface speed never has a zero magnitude
   a_neg_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |->
         (!surf_ff[0].neg || surf_ff[0].mag != '0) &&
         (!surf_ff[1].neg || surf_ff[1].mag != '0) &&
         (!surf_ff[2].neg || surf_ff[2].mag != '0) &&
         (!surf_ff[3].neg || surf_ff[3].mag != '0))
      else $error("negative surface speed with zero magnitude");

endmodule

// ----- src/mws_rpm.sv -----
// ----------------------------------------------------------------------------
// mws_rpm
// Four stages: gain product, reciprocal quotient estimate, remainder, and
// quotient correction. Gives |s| * gain / 256000000 truncated.
// ----------------------------------------------------------------------------
module mws_rpm
   import mws_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  surf_type [NUM_WHEELS-1:0] surf,
   input  logic [GAIN_W-1:0]         gain,
   output logic                      out_valid,
   input  logic                      out_stall,
   output raw_type [NUM_WHEELS-1:0]  raw
);

   localparam int NSTG        = 4;
   localparam int PROD_W      = MAG_W + GAIN_W;
   // 256000000 = 2^14 * 15625
   localparam int FRAC_SHIFT  = 14;
   localparam int DIV_LO      = 15625;
   localparam int X_W         = PROD_W - FRAC_SHIFT;
   localparam int XHI_SHIFT   = 8;
   localparam int XHI_W       = X_W - XHI_SHIFT;
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 32;
   // floor(2^40 / 15625)
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(70368744);
   localparam int EST_W       = XHI_W + RECIP_W;
   localparam int REM_W       = 16;

   typedef struct packed {
      logic              neg;
      logic [PROD_W-1:0] prod;
   } prod_type;

   typedef struct packed {
      logic             neg;
      logic [X_W-1:0]   x;
      logic [RAW_W-1:0] est;
   } est_type;

   typedef struct packed {
      logic             neg;
      logic [REM_W-1:0] rem;
      logic [RAW_W-1:0] est;
   } rem_type;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] go;

   prod_type [NUM_WHEELS-1:0] prod_ff, prod_in;
   est_type  [NUM_WHEELS-1:0] est_ff, est_in;
   rem_type  [NUM_WHEELS-1:0] rem_ff, rem_in;
   raw_type  [NUM_WHEELS-1:0] raw_ff, raw_in;

   logic [EST_W-1:0] est_full [NUM_WHEELS];
   logic [X_W-1:0]   back     [NUM_WHEELS];
   logic [X_W-1:0]   diff     [NUM_WHEELS];

   always_comb begin
      go[NSTG-1] = !valid_ff[NSTG-1] || !out_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
   end

   assign in_stall  = !go[0];
   assign out_valid = valid_ff[NSTG-1];
   assign raw       = raw_ff;

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         prod_in[w].neg  = surf[w].neg;
         prod_in[w].prod = PROD_W'(surf[w].mag) * PROD_W'(gain);

         est_in[w].neg = prod_ff[w].neg;
         est_in[w].x   = prod_ff[w].prod[PROD_W-1:FRAC_SHIFT];
         est_full[w]   = EST_W'(est_in[w].x[X_W-1:XHI_SHIFT]) * EST_W'(RECIP);
         est_in[w].est = est_full[w][RECIP_SHIFT +: RAW_W];

         back[w]       = X_W'(est_ff[w].est) * X_W'(DIV_LO);
         diff[w]       = est_ff[w].x - back[w];
         rem_in[w].neg = est_ff[w].neg;
         rem_in[w].est = est_ff[w].est;
         rem_in[w].rem = diff[w][REM_W-1:0];

         raw_in[w].neg = rem_ff[w].neg;
         if (rem_ff[w].rem >= REM_W'(2 * DIV_LO)) begin
            raw_in[w].mag = rem_ff[w].est + RAW_W'(2);
         end else if (rem_ff[w].rem >= REM_W'(DIV_LO)) begin
            raw_in[w].mag = rem_ff[w].est + RAW_W'(1);
         end else begin
            raw_in[w].mag = rem_ff[w].est;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (go[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (go[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         prod_ff <= prod_in;
      end
      if (go[1]) begin
         est_ff <= est_in;
      end
      if (go[2]) begin
         rem_ff <= rem_in;
      end
      if (go[3]) begin
         raw_ff <= raw_in;
      end
   end

   // the reciprocal estimate is never more than one short of the quotient
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |->
         rem_ff[0].rem < REM_W'(2 * DIV_LO) && rem_ff[1].rem < REM_W'(2 * DIV_LO) &&
         rem_ff[2].rem < REM_W'(2 * DIV_LO) && rem_ff[3].rem < REM_W'(2 * DIV_LO))
      else $error("quotient estimate off by more than one");

endmodule

// ----- src/mws_lim.sv -----
// ----------------------------------------------------------------------------
// mws_lim
// Largest wheel magnitude, limit compare, and a pipelined restoring divider
// giving |rpm| * limit / max one quotient bit per stage.
// ----------------------------------------------------------------------------
module mws_lim
   import mws_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  raw_type [NUM_WHEELS-1:0]    raw,
   input  logic [LIMIT_W-1:0]          limit,
   output logic                        out_valid,
   input  logic                        out_stall,
   output wheel_type [NUM_WHEELS-1:0]  wheel,
   output logic                        scaled
);

   localparam int NSTG  = LIMIT_W + 1;
   localparam int NUM_W = RAW_W + LIMIT_W;

   typedef struct packed {
      logic               neg;
      logic [RAW_W-1:0]   raw;
      logic [RAW_W-1:0]   rem;
      logic [LIMIT_W-1:0] bits;
   } div_lane_type;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] go;
   logic [NSTG-1:0] scaled_ff, scaled_in;

   div_lane_type [NUM_WHEELS-1:0] lane_ff [NSTG];
   div_lane_type [NUM_WHEELS-1:0] lane_in [NSTG];
   logic [RAW_W-1:0] max_ff [NSTG];
   logic [RAW_W-1:0] max_in [NSTG];

   logic [RAW_W-1:0] max_lo, max_hi;
   logic [NUM_W-1:0] num [NUM_WHEELS];
   logic [RAW_W:0]   trial [NSTG][NUM_WHEELS];
   logic [RAW_W:0]   diff  [NSTG][NUM_WHEELS];
   logic             ge    [NSTG][NUM_WHEELS];

   always_comb begin
      go[NSTG-1] = !valid_ff[NSTG-1] || !out_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
   end

   assign in_stall  = !go[0];
   assign out_valid = valid_ff[NSTG-1];
   assign scaled    = scaled_ff[NSTG-1];

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         wheel[w].neg = lane_ff[NSTG-1][w].neg;
         wheel[w].raw = lane_ff[NSTG-1][w].raw;
         wheel[w].quo = lane_ff[NSTG-1][w].bits;
      end
   end

   always_comb begin
      // largest magnitude and dividend setup
      max_lo       = (raw[0].mag > raw[1].mag) ? raw[0].mag : raw[1].mag;
      max_hi       = (raw[2].mag > raw[3].mag) ? raw[2].mag : raw[3].mag;
      max_in[0]    = (max_lo > max_hi) ? max_lo : max_hi;
      scaled_in[0] = (limit != '0) && (max_in[0] > RAW_W'(limit));
      for (int w = 0; w < NUM_WHEELS; w++) begin
         num[w]              = NUM_W'(raw[w].mag) * NUM_W'(limit);
         lane_in[0][w].neg   = raw[w].neg;
         lane_in[0][w].raw   = raw[w].mag;
         lane_in[0][w].rem   = num[w][NUM_W-1:LIMIT_W];
         lane_in[0][w].bits  = num[w][LIMIT_W-1:0];
         trial[0][w]         = '0;
         diff[0][w]          = '0;
         ge[0][w]            = 1'b0;
      end

      // one quotient bit per stage
      for (int k = 1; k < NSTG; k++) begin
         max_in[k]    = max_ff[k-1];
         scaled_in[k] = scaled_ff[k-1];
         for (int w = 0; w < NUM_WHEELS; w++) begin
            trial[k][w] = {lane_ff[k-1][w].rem, lane_ff[k-1][w].bits[LIMIT_W-1]};
            ge[k][w]    = trial[k][w] >= {1'b0, max_ff[k-1]};
            diff[k][w]  = trial[k][w] - {1'b0, max_ff[k-1]};
            lane_in[k][w].neg  = lane_ff[k-1][w].neg;
            lane_in[k][w].raw  = lane_ff[k-1][w].raw;
            lane_in[k][w].rem  = ge[k][w] ? diff[k][w][RAW_W-1:0] : trial[k][w][RAW_W-1:0];
            lane_in[k][w].bits = {lane_ff[k-1][w].bits[LIMIT_W-2:0], ge[k][w]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (go[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (go[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (go[k]) begin
            lane_ff[k]   <= lane_in[k];
            max_ff[k]    <= max_in[k];
            scaled_ff[k] <= scaled_in[k];
         end
      end
   end

   // the maximum is one of the four wheels
   a_max_member: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |->
         lane_ff[0][0].raw == max_ff[0] || lane_ff[0][1].raw == max_ff[0] ||
         lane_ff[0][2].raw == max_ff[0] || lane_ff[0][3].raw == max_ff[0])
      else $error("largest magnitude matches no wheel");

   // a limited wheel ends below the maximum it was divided by
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NSTG-1] && scaled_ff[NSTG-1] |->
         RAW_W'(lane_ff[NSTG-1][0].bits) < max_ff[NSTG-1] &&
         RAW_W'(lane_ff[NSTG-1][1].bits) < max_ff[NSTG-1] &&
         RAW_W'(lane_ff[NSTG-1][2].bits) < max_ff[NSTG-1] &&
         RAW_W'(lane_ff[NSTG-1][3].bits) < max_ff[NSTG-1])
      else $error("limited wheel speed not below maximum");

endmodule

// ----- src/mecanum_wheel_speed_limited.sv -----
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_limited
// Four-wheel mecanum inverse kinematics with proportional rpm limiting.
// Data passes through the two kinematics stages, four rpm conversion stages,
// the 16-stage limiter (a largest-magnitude stage, then one quotient bit per
// divider stage) and the output register.
// Throughput: one item per cycle while rsp is not stalled; bubbles are absorbed while rsp is stalled.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_limited
   import mws_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SPEED_BITS-1:0] req_forward_speed,
   input  logic signed [SPEED_BITS-1:0] req_side_speed,
   input  logic signed [SPEED_BITS-1:0] req_yaw_rate,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [RPM_BITS-1:0]   rsp_front_left_rpm,
   output logic signed [RPM_BITS-1:0]   rsp_front_right_rpm,
   output logic signed [RPM_BITS-1:0]   rsp_rear_left_rpm,
   output logic signed [RPM_BITS-1:0]   rsp_rear_right_rpm,
   output logic                         rsp_scaled_down,
   input  logic                         csr_write,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int RPM_MAX = 2 ** (RPM_BITS - 1) - 1;
   localparam logic [RPM_BITS-1:0] RPM_POS = RPM_BITS'(RPM_MAX);
   localparam logic [RPM_BITS-1:0] RPM_NEG = {1'b1, {(RPM_BITS-1){1'b0}}};

   logic [LEVER_W-1:0] lever_ff, lever_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic                      kin_stall, kin_valid, rpm_stall_up;
   surf_type [NUM_WHEELS-1:0] surf;
   logic                      rpm_valid, lim_stall_up;
   raw_type [NUM_WHEELS-1:0]  raw;
   logic                      lim_valid, lim_scaled, go_out;
   wheel_type [NUM_WHEELS-1:0] wheel;

   logic                rsp_valid_ff;
   logic                scaled_ff;
   logic [RPM_BITS-1:0] rpm_ff [NUM_WHEELS];
   logic [RPM_BITS-1:0] rpm_in [NUM_WHEELS];

   function automatic logic [RPM_BITS-1:0] rpm_out(wheel_type w, logic lim);
      logic [RAW_W-1:0]    mag;
      logic [RPM_BITS-1:0] low;
      mag = lim ? RAW_W'(w.quo) : w.raw;
      low = mag[RPM_BITS-1:0];
      if (w.neg) begin
         rpm_out = (mag > RAW_W'(RPM_MAX) + RAW_W'(1)) ? RPM_NEG : -low;
      end else begin
         rpm_out = (mag > RAW_W'(RPM_MAX)) ? RPM_POS : low;
      end
   endfunction

   // register writes
   always_comb begin
      lever_in = lever_ff;
      gain_in  = gain_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_ROTATION_LEVER: lever_in = csr_data[LEVER_W-1:0];
            REG_RPM_GAIN:       gain_in  = csr_data[GAIN_W-1:0];
            REG_RPM_LIMIT:      limit_in = csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lever_ff <= LEVER_RESET;
         gain_ff  <= GAIN_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         lever_ff <= lever_in;
         gain_ff  <= gain_in;
         limit_ff <= limit_in;
      end
   end

   mws_kin u_kin (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_stall      (kin_stall),
      .forward_speed (req_forward_speed),
      .side_speed    (req_side_speed),
      .yaw_rate      (req_yaw_rate),
      .lever         (lever_ff),
      .out_valid     (kin_valid),
      .out_stall     (rpm_stall_up),
      .surf          (surf)
   );

   mws_rpm u_rpm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (kin_valid),
      .in_stall  (rpm_stall_up),
      .surf      (surf),
      .gain      (gain_ff),
      .out_valid (rpm_valid),
      .out_stall (lim_stall_up),
      .raw       (raw)
   );

   mws_lim u_lim (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rpm_valid),
      .in_stall  (lim_stall_up),
      .raw       (raw),
      .limit     (limit_ff),
      .out_valid (lim_valid),
      .out_stall (!go_out),
      .wheel     (wheel),
      .scaled    (lim_scaled)
   );

   assign req_stall = kin_stall;

   // output register: sign, saturation
   assign go_out = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         rpm_in[w] = rpm_out(wheel[w], lim_scaled);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go_out) begin
         rsp_valid_ff <= lim_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (go_out) begin
         rpm_ff    <= rpm_in;
         scaled_ff <= lim_scaled;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_front_left_rpm  = rpm_ff[0];
   assign rsp_front_right_rpm = rpm_ff[1];
   assign rsp_rear_left_rpm   = rpm_ff[2];
   assign rsp_rear_right_rpm  = rpm_ff[3];
   assign rsp_scaled_down     = scaled_ff;

   // an empty output register lets every stage move, so req is never held
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("req stalled while output register empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result present right after reset");

endmodule
